// File: src/tmc_pkg.sv
// Shared types, constants and helpers of the transform matrix composer.
// Depends on nothing; every other file imports it.
package tmc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FX_W      = 32;
    localparam int MUL_W     = 2 * FX_W;
    localparam int PROD_W    = MUL_W - FRAC_BITS;
    localparam int ACC_W     = PROD_W + 3;
    localparam int N_ROT     = 9;

    typedef logic signed [FX_W-1:0]   t_fx;
    typedef logic signed [MUL_W-1:0]  t_mul;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam t_fx  FX_ONE  = t_fx'(64'sd1 <<< FRAC_BITS);
    localparam t_acc ACC_ONE = t_acc'(64'sd1 <<< FRAC_BITS);
    localparam t_acc ACC_MAX = t_acc'(64'sh7fff_ffff);
    localparam t_acc ACC_MIN = -t_acc'(64'sh8000_0000);

    // Operation codes
    localparam logic [2:0] OP_XFORM = 3'd0;
    localparam logic [2:0] OP_TRANS = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_QUAT  = 3'd3;
    localparam logic [2:0] OP_IDENT = 3'd4;

    // Control beat from the sequencer to each row lane
    typedef struct packed {
        logic       vld;
        logic [1:0] k;
        logic [1:0] c;
        t_fx        b;
        logic       commit;
        logic       ident;
    } t_lane_ctl;

    // Drop fraction bits, rounding toward minus infinity
    function automatic t_prod fx_trunc(input t_mul p);
        t_mul s;
        s = p >>> FRAC_BITS;
        return s[PROD_W-1:0];
    endfunction

    // Clamp an accumulated sum to the 32-bit signed range
    function automatic t_fx sat32(input t_acc v);
        t_fx r;
        if (v > ACC_MAX) begin
            r = {1'b0, {(FX_W-1){1'b1}}};
        end else if (v < ACC_MIN) begin
            r = {1'b1, {(FX_W-1){1'b0}}};
        end else begin
            r = v[FX_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/tmc_quat.sv
// Quaternion rotation builder: nine pair products on one multiplier,
// then the nine saturated 3x3 rotation entries. Depends on tmc_pkg.
module tmc_quat
    import tmc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_fx  i_a,
    input  t_fx  i_b,
    input  t_fx  i_c,
    input  t_fx  i_d,
    output logic o_done,
    output t_fx  o_rot [N_ROT]
);

    t_fx        r_a, r_b, r_c, r_d;
    logic       r_busy;
    logic [3:0] r_cnt;
    t_mul       r_p;
    logic       r_pv;
    logic [3:0] r_pidx;
    t_prod      r_pr [N_ROT];
    t_fx        m_x, m_y;
    t_acc       ii, jj, kk, ij, ik, jk, ir, jr, kr;

    // Pick the operand pair for this step
    always_comb begin
        unique case (r_cnt)
            4'd0:    begin m_x = r_a; m_y = r_a; end
            4'd1:    begin m_x = r_b; m_y = r_b; end
            4'd2:    begin m_x = r_c; m_y = r_c; end
            4'd3:    begin m_x = r_a; m_y = r_b; end
            4'd4:    begin m_x = r_a; m_y = r_c; end
            4'd5:    begin m_x = r_b; m_y = r_c; end
            4'd6:    begin m_x = r_a; m_y = r_d; end
            4'd7:    begin m_x = r_b; m_y = r_d; end
            4'd8:    begin m_x = r_c; m_y = r_d; end
            default: begin m_x = r_a; m_y = r_a; end
        endcase
    end

    // Control: count through the pairs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 4'd0;
            r_pv   <= 1'b0;
        end else begin
            r_pv <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (r_busy) begin
                if (r_cnt == 4'(N_ROT - 1)) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

    // Datapath: multiply, then store the truncated product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_c <= i_c;
            r_d <= i_d;
        end
        r_p    <= MUL_W'(m_x) * MUL_W'(m_y);
        r_pidx <= r_cnt;
        if (r_pv) begin
            r_pr[r_pidx] <= fx_trunc(r_p);
        end
    end

    assign o_done = r_pv && (r_pidx == 4'(N_ROT - 1));

    // Build rotation entries from the stored products
    assign ii = ACC_W'(r_pr[0]);
    assign jj = ACC_W'(r_pr[1]);
    assign kk = ACC_W'(r_pr[2]);
    assign ij = ACC_W'(r_pr[3]);
    assign ik = ACC_W'(r_pr[4]);
    assign jk = ACC_W'(r_pr[5]);
    assign ir = ACC_W'(r_pr[6]);
    assign jr = ACC_W'(r_pr[7]);
    assign kr = ACC_W'(r_pr[8]);

    assign o_rot[0] = sat32(ACC_ONE - ((jj + kk) <<< 1));
    assign o_rot[1] = sat32((ij <<< 1) - (kr <<< 1));
    assign o_rot[2] = sat32((ik <<< 1) + (jr <<< 1));
    assign o_rot[3] = sat32((ij <<< 1) + (kr <<< 1));
    assign o_rot[4] = sat32(ACC_ONE - ((ii + kk) <<< 1));
    assign o_rot[5] = sat32((jk <<< 1) - (ir <<< 1));
    assign o_rot[6] = sat32((ik <<< 1) - (jr <<< 1));
    assign o_rot[7] = sat32((jk <<< 1) + (ir <<< 1));
    assign o_rot[8] = sat32(ACC_ONE - ((ii + jj) <<< 1));

endmodule

// File: src/tmc_lane.sv
// One matrix row lane: holds its row, multiplies row[k] by a broadcast
// operand and accumulates 4-term dot products. Depends on tmc_pkg.
module tmc_lane
    import tmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [1:0] i_lane,
    input  t_lane_ctl i_ctl,
    output t_fx       o_dot
);

    t_fx        r_row [4];
    t_fx        r_new [4];
    t_mul       r_p;
    logic       r_pv;
    logic [1:0] r_pk, r_pc;
    t_acc       r_acc;
    t_acc       sum;

    // Add this product to the running sum
    assign sum = (r_pk == 2'd0 ? '0 : r_acc) + ACC_W'(fx_trunc(r_p));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // Row storage: reset, identity load or commit of the new row
        if (!i_rst_n || i_ctl.ident) begin
            for (int n = 0; n < 4; n++) begin
                r_row[n] <= (n == int'(i_lane)) ? FX_ONE : '0;
            end
        end else if (i_ctl.commit) begin
            for (int n = 0; n < 4; n++) begin
                r_row[n] <= r_new[n];
            end
        end
        // Multiply stage
        r_p  <= MUL_W'(r_row[i_ctl.k]) * MUL_W'(i_ctl.b);
        r_pk <= i_ctl.k;
        r_pc <= i_ctl.c;
        // Accumulate stage
        if (r_pv) begin
            r_acc <= sum;
            if (r_pk == 2'd3) begin
                r_new[r_pc] <= sat32(sum);
            end
        end
    end

    assign o_dot = r_new[0];

endmodule

// File: src/transform_matrix_composer_top.sv
// Top level of the transform matrix composer: sequencer, four row lanes,
// quaternion builder and output register. Depends on tmc_pkg, tmc_lane, tmc_quat.
//
// Keeps a 4x4 Q16.16 matrix (identity after reset) and applies one operation
// per input beat: transform a vector, translate, scale, quaternion rotate or
// reset to identity. Input beat: i_in_valid / o_in_stall with the operation
// and four operands. Output beat: o_out_valid / i_out_stall with out_x..w,
// only for vector transforms.
// Four row lanes, each with one 32x32 multiplier, work side by side; every
// lane steps through the four terms of a dot product, one per cycle.
// Vector transform: issue the dot-product terms, drain the lanes, then load the
// output register; no new beat is taken until the sequencer is idle. Translate
// and scale issue 16 lane products per row. Quaternion rotate first forms the
// shared-multiplier products. Reset to identity acts as the beat is accepted.
// Reset (synchronous, active low) restores identity and empties the output.
// A stalled result stays in the output register while the next beat is
// accepted; a following vector result waits until that one is taken.
module transform_matrix_composer_top
    import tmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_operation,
    input  t_fx        i_operand_a,
    input  t_fx        i_operand_b,
    input  t_fx        i_operand_c,
    input  t_fx        i_operand_d,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_fx        o_out_x,
    output t_fx        o_out_y,
    output t_fx        o_out_z,
    output t_fx        o_out_w
);

    typedef enum logic [2:0] {S_IDLE, S_QUAT, S_ISSUE, S_DRAIN, S_FIN} t_state;

    t_state     r_state;
    logic [2:0] r_op;
    t_fx        r_a, r_b, r_c, r_d;
    logic [3:0] r_step;
    logic       r_out_vld;
    t_fx        r_out [4];

    logic       in_acc, out_take, out_free, q_done;
    logic [1:0] s_k, s_c;
    t_fx        t_sel;
    t_fx        rot [N_ROT];
    t_fx        dot [4];
    t_lane_ctl  ctl;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_take   = r_out_vld && !i_out_stall;
    assign out_free   = !r_out_vld || out_take;

    assign s_k = r_step[1:0];
    assign s_c = r_step[3:2];

    // Select the multiplier operand: vector element or T[k][c]
    always_comb begin
        t_sel = (s_k == s_c) ? FX_ONE : '0;
        unique case (r_op)
            OP_XFORM: begin
                unique case (s_k)
                    2'd0: t_sel = r_a;
                    2'd1: t_sel = r_b;
                    2'd2: t_sel = r_c;
                    2'd3: t_sel = r_d;
                endcase
            end
            OP_TRANS: begin
                if (s_c == 2'd3) begin
                    unique case (s_k)
                        2'd0: t_sel = r_a;
                        2'd1: t_sel = r_b;
                        2'd2: t_sel = r_c;
                        2'd3: t_sel = FX_ONE;
                    endcase
                end
            end
            OP_SCALE: begin
                if (s_k == s_c) begin
                    unique case (s_k)
                        2'd0: t_sel = r_a;
                        2'd1: t_sel = r_b;
                        2'd2: t_sel = r_c;
                        2'd3: t_sel = FX_ONE;
                    endcase
                end
            end
            OP_QUAT: begin
                if (s_k != 2'd3 && s_c != 2'd3) begin
                    t_sel = rot[4'(s_k) * 4'd3 + 4'(s_c)];
                end
            end
            default: t_sel = '0;
        endcase
    end

    // Control beat to the lanes
    always_comb begin
        ctl.vld    = (r_state == S_ISSUE);
        ctl.k      = s_k;
        ctl.c      = s_c;
        ctl.b      = t_sel;
        ctl.commit = (r_state == S_FIN) && (r_op != OP_XFORM);
        ctl.ident  = in_acc && (i_operation == OP_IDENT);
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= 4'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (out_take) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_step <= 4'd0;
                    if (in_acc) begin
                        priority case (i_operation)
                            OP_XFORM, OP_TRANS, OP_SCALE: r_state <= S_ISSUE;
                            OP_QUAT:                      r_state <= S_QUAT;
                            default:                      r_state <= S_IDLE;
                        endcase
                    end
                end
                S_QUAT: begin
                    if (q_done) begin
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_step <= r_step + 4'd1;
                    if ((r_op == OP_XFORM && r_step == 4'd3) || r_step == 4'd15) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_FIN;
                S_FIN: begin
                    if (r_op != OP_XFORM) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Hold operands and the result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op <= i_operation;
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
            r_c  <= i_operand_c;
            r_d  <= i_operand_d;
        end
        if (r_state == S_FIN && r_op == OP_XFORM && out_free) begin
            for (int n = 0; n < 4; n++) begin
                r_out[n] <= dot[n];
            end
        end
    end

    tmc_quat u_quat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && i_operation == OP_QUAT),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .i_c     (i_operand_c),
        .i_d     (i_operand_d),
        .o_done  (q_done),
        .o_rot   (rot)
    );

    for (genvar g = 0; g < 4; g++) begin : g_lane
        tmc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (2'(g)),
            .i_ctl   (ctl),
            .o_dot   (dot[g])
        );
    end

    assign o_out_valid = r_out_vld;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_out_w     = r_out[3];

endmodule
